/* hdl/ffba_pkg.sv */
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator: field widths,
// result codes, table entry layout and the controller-to-datapath interface.
// ----------------------------------------------------------------------------
package ffba_pkg;

    localparam int FUNC_W   = 1;
    localparam int REQ_W    = 21;
    localparam int REL_W    = 20;
    localparam int STATUS_W = 2;
    localparam int OFS_W    = 20;
    localparam int FREE_W   = 21;
    localparam int START_W  = 20;
    localparam int BYTES_W  = 21;
    localparam int NEED_W   = 22;

    typedef enum logic [STATUS_W-1:0] {
        RES_OK      = 2'd0,
        RES_FAIL    = 2'd1,
        RES_UNKNOWN = 2'd2
    } t_status;

    typedef enum logic [FUNC_W-1:0] {
        FN_ALLOC = 1'b0,
        FN_FREE  = 1'b1
    } t_func;

    typedef struct packed {
        logic [START_W-1:0] start;
        logic [BYTES_W-1:0] bytes;
        logic               is_free;
    } t_entry;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_LOAD,
        OP_MOD,
        OP_NEED,
        OP_SCAN,
        OP_AHIT,
        OP_UP,
        OP_SPLIT,
        OP_FHIT,
        OP_FNEXT,
        OP_FWR,
        OP_DOWN,
        OP_RESULT
    } t_op;

    typedef struct packed {
        logic trivial;
        logic in_free;
        logic func_free;
        logic mod_last;
        logic hit;
        logic scan_end;
        logic split;
        logic up_done;
        logic no_remove;
        logic down_done;
    } t_dp_status;

endpackage

/* hdl/ffba_ctrl.sv */
// ----------------------------------------------------------------------------
// ffba_ctrl
// Controller state machine. Sequences the datapath through the size rounding,
// table scan, split and merge steps, and owns both handshakes.
// ----------------------------------------------------------------------------
module ffba_ctrl
    import ffba_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    output logic       o_valid,
    input  logic       i_stall,
    input  t_dp_status i_st,
    output t_op        o_op
);

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_MOD,
        S_NEED,
        S_SCAN,
        S_AHIT,
        S_UP,
        S_SPLIT,
        S_FHIT,
        S_FNEXT,
        S_FWR,
        S_DOWN,
        S_FIN
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_stall;
    logic   r_ovalid;
    logic   n_ovalid;
    logic   out_free;
    logic   accept;

    assign out_free = !r_ovalid || !i_stall;
    assign accept   = (r_state == S_IDLE) && i_valid;

    always_comb begin
        n_state = r_state;
        o_op    = OP_NONE;
        unique case (r_state)
            S_INIT: begin
                o_op    = OP_INIT;
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    o_op = OP_LOAD;
                    if (i_st.trivial) begin
                        n_state = S_FIN;
                    end else if (i_st.in_free) begin
                        n_state = S_SCAN;
                    end else begin
                        n_state = S_MOD;
                    end
                end
            end
            S_MOD: begin
                o_op = OP_MOD;
                if (i_st.mod_last) begin
                    n_state = S_NEED;
                end
            end
            S_NEED: begin
                o_op    = OP_NEED;
                n_state = S_SCAN;
            end
            S_SCAN: begin
                o_op = OP_SCAN;
                priority if (i_st.hit) begin
                    n_state = i_st.func_free ? S_FHIT : S_AHIT;
                end else if (i_st.scan_end) begin
                    n_state = S_FIN;
                end else begin
                    n_state = S_SCAN;
                end
            end
            S_AHIT: begin
                o_op    = OP_AHIT;
                n_state = i_st.split ? S_UP : S_FIN;
            end
            S_UP: begin
                o_op = OP_UP;
                if (i_st.up_done) begin
                    n_state = S_SPLIT;
                end
            end
            S_SPLIT: begin
                o_op    = OP_SPLIT;
                n_state = S_FIN;
            end
            S_FHIT: begin
                o_op    = OP_FHIT;
                n_state = S_FNEXT;
            end
            S_FNEXT: begin
                o_op    = OP_FNEXT;
                n_state = S_FWR;
            end
            S_FWR: begin
                o_op    = OP_FWR;
                n_state = i_st.no_remove ? S_FIN : S_DOWN;
            end
            S_DOWN: begin
                o_op = OP_DOWN;
                if (i_st.down_done) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    o_op    = OP_RESULT;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_INIT;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        priority if ((r_state == S_FIN) && out_free) begin
            n_ovalid = 1'b1;
        end else if (r_ovalid && !i_stall) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_INIT;
            r_stall  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_stall  <= (n_state != S_IDLE);
            r_ovalid <= n_ovalid;
        end
    end

    assign o_stall = r_stall;
    assign o_valid = r_ovalid;

endmodule

/* hdl/ffba_datapath.sv */
// ----------------------------------------------------------------------------
// ffba_datapath
// Block table memory, counters, size rounding unit and result registers.
// Executes one controller operation per cycle.
// ----------------------------------------------------------------------------
module ffba_datapath
    import ffba_pkg::*;
#(
    parameter int HEAP_BYTES   = 1048576,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_op                 i_op,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [REQ_W-1:0]    i_request_bytes,
    input  logic [REL_W-1:0]    i_release_offset,
    output t_dp_status          o_st,
    output logic [STATUS_W-1:0] o_status,
    output logic [OFS_W-1:0]    o_data_offset,
    output logic [FREE_W-1:0]   o_free_bytes
);

    localparam int CW = $clog2(MAX_BLOCKS + 1);
    localparam int IW = $clog2(MAX_BLOCKS);
    localparam int ALN_LOG = $clog2(ALIGN_BYTES);
    localparam int QSH = NEED_W + ALN_LOG;
    localparam int MW = NEED_W + 1;
    localparam int PW = NEED_W + MW;
    localparam longint RECIP_L = ((longint'(1) << QSH) + longint'(ALIGN_BYTES) - 1)
                                 / longint'(ALIGN_BYTES);
    localparam logic [MW-1:0] RECIP = MW'(RECIP_L);
    localparam logic [BYTES_W-1:0] HDR_B = BYTES_W'(HEADER_BYTES);
    localparam logic [START_W-1:0] HDR_S = START_W'(HEADER_BYTES);
    localparam logic [BYTES_W-1:0] INIT_BYTES = BYTES_W'(HEAP_BYTES - HEADER_BYTES);
    localparam logic [CW-1:0] MAX_C = CW'(MAX_BLOCKS);

    t_entry r_mem [MAX_BLOCKS];
    t_entry r_rdata;
    logic              mem_we;
    logic [IW-1:0]     mem_waddr;
    logic [IW-1:0]     mem_raddr;
    t_entry            mem_wdata;

    logic [CW-1:0]      r_count;
    logic [BYTES_W-1:0] r_free_total;
    t_func              r_func;
    logic [REQ_W-1:0]   r_req;
    logic [REL_W-1:0]   r_rel;
    logic [NEED_W-1:0]  r_quot;
    logic [NEED_W-1:0]  r_need;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_widx;
    logic               r_pend;
    t_entry             r_cur;
    t_entry             r_prev;
    logic               r_prev_ok;
    logic [CW-1:0]      r_k;
    logic [CW-1:0]      r_base;
    logic [START_W-1:0] r_bstart;
    logic [BYTES_W-1:0] r_acc;
    logic               r_pf;
    logic               r_hasnext;
    logic [1:0]         r_rm;
    t_status            r_status;
    logic [OFS_W-1:0]   r_offset;
    logic [STATUS_W-1:0] r_o_status;
    logic [OFS_W-1:0]    r_o_offset;
    logic [FREE_W-1:0]   r_o_free;

    logic               cand_alloc;
    logic               cand_free;
    logic               hit;
    logic [BYTES_W-1:0] rest;
    logic               split;
    logic [NEED_W-1:0]  rnd;
    logic [PW-1:0]      prod;
    logic               pf;
    logic               nf;

    function automatic logic [BYTES_W-1:0] less_hdr(input logic [BYTES_W-1:0] value);
        return value - HDR_B;
    endfunction

    assign cand_alloc = r_rdata.is_free && ({1'b0, r_rdata.bytes} >= r_need);
    assign cand_free  = !r_rdata.is_free
                        && (({1'b0, r_rdata.start} + {1'b0, HDR_S}) == {1'b0, r_rel});
    assign hit   = r_pend && ((r_func == FN_FREE) ? cand_free : cand_alloc);
    assign rest  = r_cur.bytes - r_need[BYTES_W-1:0];
    assign split = (rest > HDR_B) && (r_count < MAX_C);
    assign rnd   = {1'b0, r_req} + NEED_W'(ALIGN_BYTES - 1);
    assign prod  = PW'(rnd) * PW'(RECIP);
    assign pf    = r_prev_ok && r_prev.is_free;
    assign nf    = r_hasnext && r_rdata.is_free;

    always_comb begin
        o_st.trivial   = (i_func == FN_FREE) ? (i_release_offset == '0)
                                             : (i_request_bytes == '0);
        o_st.in_free   = (i_func == FN_FREE);
        o_st.func_free = (r_func == FN_FREE);
        o_st.mod_last  = 1'b1;
        o_st.hit       = hit;
        o_st.scan_end  = !r_pend && (r_idx >= r_count);
        o_st.split     = split;
        o_st.up_done   = !r_pend && (r_idx <= r_k + CW'(1));
        o_st.no_remove = (r_rm == 2'd0);
        o_st.down_done = !r_pend && (r_idx >= r_count);
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_widx[IW-1:0];
        mem_wdata = r_rdata;
        mem_raddr = r_idx[IW-1:0];
        unique case (i_op)
            OP_INIT: begin
                mem_we    = 1'b1;
                mem_waddr = '0;
                mem_wdata = '{start: '0, bytes: INIT_BYTES, is_free: 1'b1};
            end
            OP_AHIT: begin
                mem_we    = 1'b1;
                mem_waddr = r_k[IW-1:0];
                mem_wdata = '{start: r_cur.start,
                              bytes: split ? r_need[BYTES_W-1:0] : r_cur.bytes,
                              is_free: 1'b0};
            end
            OP_UP: begin
                mem_raddr = IW'(r_idx - CW'(1));
                mem_we    = r_pend;
            end
            OP_SPLIT: begin
                mem_we    = 1'b1;
                mem_waddr = IW'(r_k + CW'(1));
                mem_wdata = '{start: r_cur.start + HDR_S + r_need[START_W-1:0],
                              bytes: less_hdr(rest),
                              is_free: 1'b1};
            end
            OP_FHIT: begin
                mem_raddr = IW'(r_k + CW'(1));
            end
            OP_FWR: begin
                mem_we    = 1'b1;
                mem_waddr = r_base[IW-1:0];
                mem_wdata = '{start: r_bstart, bytes: r_acc, is_free: 1'b1};
            end
            OP_DOWN: begin
                mem_raddr = IW'(r_idx + CW'(r_rm));
                mem_we    = r_pend;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            unique case (i_op)
                OP_INIT: begin
                    r_count      <= CW'(1);
                    r_free_total <= INIT_BYTES;
                end
                OP_LOAD: begin
                    r_func    <= t_func'(i_func);
                    r_req     <= i_request_bytes;
                    r_rel     <= i_release_offset;
                    r_idx     <= '0;
                    r_pend    <= 1'b0;
                    r_prev_ok <= 1'b0;
                    r_offset  <= '0;
                    if (i_func == FN_FREE) begin
                        r_status <= (i_release_offset == '0) ? RES_OK : RES_UNKNOWN;
                    end else begin
                        r_status <= RES_FAIL;
                    end
                end
                OP_MOD: begin
                    r_quot <= NEED_W'(prod >> QSH);
                end
                OP_NEED: begin
                    r_need <= r_quot * NEED_W'(ALIGN_BYTES);
                end
                OP_SCAN: begin
                    if (hit) begin
                        r_cur  <= r_rdata;
                        r_k    <= r_widx;
                        r_pend <= 1'b0;
                    end else begin
                        if (r_pend) begin
                            r_prev    <= r_rdata;
                            r_prev_ok <= 1'b1;
                        end
                        r_pend <= (r_idx < r_count);
                        if (r_idx < r_count) begin
                            r_widx <= r_idx;
                            r_idx  <= r_idx + CW'(1);
                        end
                    end
                end
                OP_AHIT: begin
                    r_status <= RES_OK;
                    r_offset <= r_cur.start + HDR_S;
                    if (split) begin
                        r_count      <= r_count + CW'(1);
                        r_free_total <= r_free_total - (r_need[BYTES_W-1:0] + HDR_B);
                        r_idx        <= r_count;
                        r_pend       <= 1'b0;
                    end else begin
                        r_free_total <= r_free_total - r_cur.bytes;
                    end
                end
                OP_UP: begin
                    r_pend <= (r_idx > r_k + CW'(1));
                    if (r_idx > r_k + CW'(1)) begin
                        r_widx <= r_idx;
                        r_idx  <= r_idx - CW'(1);
                    end
                end
                OP_FHIT: begin
                    r_status     <= RES_OK;
                    r_pf         <= pf;
                    r_hasnext    <= (r_k + CW'(1) < r_count);
                    r_acc        <= r_cur.bytes + (pf ? (r_prev.bytes + HDR_B) : '0);
                    r_base       <= pf ? (r_k - CW'(1)) : r_k;
                    r_bstart     <= pf ? r_prev.start : r_cur.start;
                    r_free_total <= r_free_total + r_cur.bytes + (pf ? HDR_B : '0);
                end
                OP_FNEXT: begin
                    r_acc        <= r_acc + (nf ? (HDR_B + r_rdata.bytes) : '0);
                    r_free_total <= r_free_total + (nf ? HDR_B : '0);
                    r_rm         <= {1'b0, r_pf} + {1'b0, nf};
                end
                OP_FWR: begin
                    r_count <= r_count - CW'(r_rm);
                    r_idx   <= r_base + CW'(1);
                    r_pend  <= 1'b0;
                end
                OP_DOWN: begin
                    r_pend <= (r_idx < r_count);
                    if (r_idx < r_count) begin
                        r_widx <= r_idx;
                        r_idx  <= r_idx + CW'(1);
                    end
                end
                OP_RESULT: begin
                    r_o_status <= r_status;
                    r_o_offset <= r_offset;
                    r_o_free   <= r_free_total;
                end
                default: begin
                    r_pend <= r_pend;
                end
            endcase
        end
    end

    assign o_status      = r_o_status;
    assign o_data_offset = r_o_offset;
    assign o_free_bytes  = r_o_free;

endmodule

/* hdl/first_fit_block_allocator_top.sv */
// ----------------------------------------------------------------------------
// first_fit_block_allocator_top
// First-fit heap allocator with coalescing of free neighbors.
//
// The input channel carries allocate and free requests; the output channel
// returns one result per request with status, granted data offset and the
// total free bytes. A transfer takes place when valid is high and stall is
// low on that channel.
// An allocate rounds its size up with a reciprocal multiply and a scaling by
// the alignment, then scans the block table memory at one entry per cycle.
// A split shifts the upper part of the table up one entry per cycle; a merge
// shifts it down the same way. A null request goes straight to the result
// state, which loads the output register once it is free. o_stall drops in
// the same cycle that the result appears, so the next request can be taken
// then; one request is in work at a time. The table memory's single read and
// write port sets the scan and shift rates. After reset the block writes the
// initial table entry in its INIT state with o_stall high. A finished result
// sits in the output register; while the receiver stalls it holds, and the
// next request is still taken and worked on, waiting only at its own result.
// ----------------------------------------------------------------------------
module first_fit_block_allocator_top
    import ffba_pkg::*;
#(
    parameter int HEAP_BYTES   = 1048576,
    parameter int MAX_BLOCKS   = 64,
    parameter int HEADER_BYTES = 24,
    parameter int ALIGN_BYTES  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [REQ_W-1:0]    i_request_bytes,
    input  logic [REL_W-1:0]    i_release_offset,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [STATUS_W-1:0] o_status,
    output logic [OFS_W-1:0]    o_data_offset,
    output logic [FREE_W-1:0]   o_free_bytes
);

    t_op        op;
    t_dp_status st;

    ffba_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_st    (st),
        .o_op    (op)
    );

    ffba_datapath #(
        .HEAP_BYTES   (HEAP_BYTES),
        .MAX_BLOCKS   (MAX_BLOCKS),
        .HEADER_BYTES (HEADER_BYTES),
        .ALIGN_BYTES  (ALIGN_BYTES)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_op             (op),
        .i_func           (i_func),
        .i_request_bytes  (i_request_bytes),
        .i_release_offset (i_release_offset),
        .o_st             (st),
        .o_status         (o_status),
        .o_data_offset    (o_data_offset),
        .o_free_bytes     (o_free_bytes)
    );

endmodule

/* hdl/ffba_checker.sv */
// ----------------------------------------------------------------------------
// ffba_checker
// Port-level checks of the allocator: request sequencing, result codes and
// the output register's behavior under stall.
// ----------------------------------------------------------------------------
module ffba_checker
    import ffba_pkg::*;
#(
    parameter int HEAP_BYTES   = 1048576,
    parameter int HEADER_BYTES = 24
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                o_stall,
    input logic                o_valid,
    input logic                i_stall,
    input logic [STATUS_W-1:0] o_status,
    input logic [OFS_W-1:0]    o_data_offset,
    input logic [FREE_W-1:0]   o_free_bytes
);

    localparam logic [FREE_W-1:0] FREE_MAX = FREE_W'(HEAP_BYTES - HEADER_BYTES);

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> o_stall)
        else $error("Input transfer was not followed by stall.");

    a_result_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=> (o_valid && $stable(o_status)
                                  && $stable(o_data_offset) && $stable(o_free_bytes)))
        else $error("Stalled result changed.");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_status == RES_OK || o_status == RES_FAIL
                     || o_status == RES_UNKNOWN))
        else $error("Result carries an undefined status.");

    a_no_offset_on_error: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != RES_OK) |-> (o_data_offset == '0))
        else $error("Failed request returned a data offset.");

    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_free_bytes <= FREE_MAX))
        else $error("Free byte count exceeds the heap.");

endmodule

bind first_fit_block_allocator_top ffba_checker #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
) u_ffba_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_valid       (i_valid),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_status      (o_status),
    .o_data_offset (o_data_offset),
    .o_free_bytes  (o_free_bytes)
);
